@@ rtl/power_series_division_mod_prime_macros.svh @@
// Assertion helpers, clocked on i_clk and disabled during reset.
`ifndef POWER_SERIES_DIVISION_MOD_PRIME_MACROS_SVH
`define POWER_SERIES_DIVISION_MOD_PRIME_MACROS_SVH

// Same-cycle implication.
`define PSDMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSDMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/psdmp_pkg.sv @@
package psdmp_pkg;

    localparam int COEF_W = 30;

    localparam logic [COEF_W-1:0] MODULUS   = 30'd998244353;
    // -MODULUS^-1 mod 2^32
    localparam logic [31:0]       MONT_NINV = 32'h3B7F_FFFF;
    // 2^64 mod MODULUS, brings a Montgomery-scaled sum back to plain form
    localparam logic [COEF_W-1:0] MONT_R2   = 30'd932051910;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_FIX,
        S_FWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic vld;
        logic busy;
    } t_mm_status;

endpackage

@@ rtl/psdmp_ifs.sv @@
interface psdmp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          start_series;
    logic                          last_term;
    logic [psdmp_pkg::COEF_W-1:0]  num_coef;
    logic [psdmp_pkg::COEF_W-1:0]  den_coef;

    modport source (output valid, start_series, last_term, num_coef, den_coef,
                    input ready);
    modport sink   (input valid, start_series, last_term, num_coef, den_coef,
                    output ready);
endinterface

interface psdmp_out_if;
    logic                          valid;
    logic                          ready;
    logic [psdmp_pkg::COEF_W-1:0]  quot_coef;
    logic                          is_last;
    logic                          too_long;

    modport source (output valid, quot_coef, is_last, too_long, input ready);
    modport sink   (input valid, quot_coef, is_last, too_long, output ready);
endinterface

@@ rtl/psdmp_mulmod.sv @@
// Pipelined Montgomery multiplier, R = 2^32: o_res = a*b*R^-1 mod MODULUS.
// Four stages, one operand pair per cycle.
module psdmp_mulmod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [psdmp_pkg::COEF_W-1:0]  i_a,
    input  logic [psdmp_pkg::COEF_W-1:0]  i_b,
    output logic [psdmp_pkg::COEF_W-1:0]  o_res,
    output psdmp_pkg::t_mm_status         o_stat
);

    logic [3:0]  r_vld;
    logic [59:0] r_t1;
    logic [59:0] r_t2;
    logic [59:0] r_t3;
    logic [31:0] r_m;
    logic [61:0] r_mp;
    logic [psdmp_pkg::COEF_W-1:0] r_u;

    logic [59:0] n_t1;
    logic [31:0] n_m;
    logic [61:0] n_mp;
    logic [62:0] sum_w;
    logic [30:0] u_w;
    logic [psdmp_pkg::COEF_W-1:0] n_u;

    always_comb begin
        n_t1  = 60'(i_a) * 60'(i_b);
        n_m   = r_t1[31:0] * psdmp_pkg::MONT_NINV;
        n_mp  = 62'(r_m) * 62'(psdmp_pkg::MODULUS);
        sum_w = 63'(r_t3) + 63'(r_mp);
        u_w   = sum_w[62:32];
        if (u_w >= 31'(psdmp_pkg::MODULUS)) begin
            n_u = 30'(u_w - 31'(psdmp_pkg::MODULUS));
        end else begin
            n_u = u_w[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
        r_t1 <= n_t1;
        r_t2 <= r_t1;
        r_m  <= n_m;
        r_t3 <= r_t2;
        r_mp <= n_mp;
        r_u  <= n_u;
    end

    assign o_res       = r_u;
    assign o_stat.vld  = r_vld[3];
    assign o_stat.busy = |r_vld;

endmodule

@@ rtl/power_series_division_mod_prime.sv @@
// Online power series division p/q mod 998244353 with q[0] taken as 1. One
// transaction in gives one transaction out. For term i > 0 of a division the
// input is ready again when the output is loaded. The sequencer streams the i
// stored quotient/denominator pairs through one pipelined Montgomery
// multiplier, one pair per cycle, waits for the pipeline to empty, then uses
// the same multiplier once more to rescale the sum. Term zero, and terms at or
// beyond MAX_TERMS (zero with too_long set), bypass the multiplier. The input
// is not ready while a term is in progress; a finished result waits in the
// output register while the next transaction is taken.
`include "power_series_division_mod_prime_macros.svh"

module power_series_division_mod_prime #(
    parameter int MAX_TERMS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psdmp_in_if.sink      i_in,
    psdmp_out_if.source   o_out
);

    localparam int AW = $clog2(MAX_TERMS);
    localparam int TW = $clog2(MAX_TERMS + 1);
    localparam logic [TW-1:0] TERM_LIMIT = TW'(MAX_TERMS);
    localparam int CW = psdmp_pkg::COEF_W;

    psdmp_pkg::t_state r_state, n_state;
    logic [TW-1:0] r_term, n_term;
    logic          r_restart, n_restart;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [CW-1:0] r_num, n_num;
    logic          r_last, n_last;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_res, n_res;
    logic [CW-1:0] r_acc, n_acc;
    logic          r_ovalid, n_ovalid;
    logic [CW-1:0] r_oq, n_oq;
    logic          r_olast, n_olast;
    logic          r_oovf, n_oovf;
    logic          r_rd_vld;
    logic [CW-1:0] r_qrd;
    logic [CW-1:0] r_drd;

    logic [CW-1:0] quot_mem [MAX_TERMS];
    logic [CW-1:0] den_mem  [MAX_TERMS];

    logic          issue;
    logic          q_we;
    logic [AW-1:0] q_waddr;
    logic [CW-1:0] q_wdata;
    logic          d_we;
    logic [AW-1:0] d_raddr;
    logic [TW-1:0] idx;
    logic [CW-1:0] num_red;
    logic [CW-1:0] den_red;
    logic [CW:0]   acc_w;
    logic [CW-1:0] acc_red;
    logic [CW-1:0] diff;

    logic                  mm_vld;
    logic [CW-1:0]         mm_a;
    logic [CW-1:0]         mm_b;
    logic [CW-1:0]         mm_res;
    psdmp_pkg::t_mm_status mm_stat;

    psdmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (mm_vld),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .o_res   (mm_res),
        .o_stat  (mm_stat)
    );

    always_comb begin
        idx = (i_in.start_series || r_restart) ? '0 : r_term;

        num_red = (i_in.num_coef >= psdmp_pkg::MODULUS) ?
                  (i_in.num_coef - psdmp_pkg::MODULUS) : i_in.num_coef;
        den_red = (i_in.den_coef >= psdmp_pkg::MODULUS) ?
                  (i_in.den_coef - psdmp_pkg::MODULUS) : i_in.den_coef;

        acc_w = {1'b0, r_acc} + {1'b0, mm_res};
        if (acc_w >= {1'b0, psdmp_pkg::MODULUS}) begin
            acc_red = CW'(acc_w - {1'b0, psdmp_pkg::MODULUS});
        end else begin
            acc_red = acc_w[CW-1:0];
        end

        if (r_num >= mm_res) begin
            diff = r_num - mm_res;
        end else begin
            diff = CW'({1'b0, r_num} + {1'b0, psdmp_pkg::MODULUS} - {1'b0, mm_res});
        end
    end

    assign d_raddr = r_i - r_j;

    always_comb begin
        n_state   = r_state;
        n_term    = r_term;
        n_restart = r_restart;
        n_i       = r_i;
        n_j       = r_j;
        n_num     = r_num;
        n_last    = r_last;
        n_ovf     = r_ovf;
        n_res     = r_res;
        n_acc     = r_acc;
        n_ovalid  = r_ovalid;
        n_oq      = r_oq;
        n_olast   = r_olast;
        n_oovf    = r_oovf;
        issue     = 1'b0;
        q_we      = 1'b0;
        q_waddr   = r_i;
        q_wdata   = diff;
        d_we      = 1'b0;
        mm_vld    = r_rd_vld;
        mm_a      = r_qrd;
        mm_b      = r_drd;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        if (mm_stat.vld &&
            (r_state == psdmp_pkg::S_ISSUE || r_state == psdmp_pkg::S_DRAIN)) begin
            n_acc = acc_red;
        end

        unique case (r_state)
            psdmp_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_restart = i_in.last_term;
                    n_last    = i_in.last_term;
                    n_num     = num_red;
                    if (idx >= TERM_LIMIT) begin
                        n_ovf   = 1'b1;
                        n_res   = '0;
                        n_term  = TERM_LIMIT;
                        n_state = psdmp_pkg::S_DONE;
                    end else begin
                        n_ovf  = 1'b0;
                        d_we   = 1'b1;
                        n_i    = idx[AW-1:0];
                        n_j    = '0;
                        n_acc  = '0;
                        n_term = idx + TW'(1);
                        if (idx == '0) begin
                            n_res   = num_red;
                            q_we    = 1'b1;
                            q_waddr = '0;
                            q_wdata = num_red;
                            n_state = psdmp_pkg::S_DONE;
                        end else begin
                            n_state = psdmp_pkg::S_ISSUE;
                        end
                    end
                end
            end
            psdmp_pkg::S_ISSUE: begin
                issue = 1'b1;
                n_j   = r_j + AW'(1);
                if (r_j == r_i - AW'(1)) begin
                    n_state = psdmp_pkg::S_DRAIN;
                end
            end
            psdmp_pkg::S_DRAIN: begin
                if (!r_rd_vld && !mm_stat.busy) begin
                    n_state = psdmp_pkg::S_FIX;
                end
            end
            psdmp_pkg::S_FIX: begin
                mm_vld  = 1'b1;
                mm_a    = r_acc;
                mm_b    = psdmp_pkg::MONT_R2;
                n_state = psdmp_pkg::S_FWAIT;
            end
            psdmp_pkg::S_FWAIT: begin
                if (mm_stat.vld) begin
                    n_res   = diff;
                    q_we    = 1'b1;
                    n_state = psdmp_pkg::S_DONE;
                end
            end
            psdmp_pkg::S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oq     = r_res;
                    n_olast  = r_last;
                    n_oovf   = r_ovf;
                    n_state  = psdmp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = psdmp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psdmp_pkg::S_IDLE;
            r_term    <= '0;
            r_restart <= 1'b0;
            r_ovalid  <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_term    <= n_term;
            r_restart <= n_restart;
            r_ovalid  <= n_ovalid;
            r_rd_vld  <= issue;
        end
        r_i     <= n_i;
        r_j     <= n_j;
        r_num   <= n_num;
        r_last  <= n_last;
        r_ovf   <= n_ovf;
        r_res   <= n_res;
        r_acc   <= n_acc;
        r_oq    <= n_oq;
        r_olast <= n_olast;
        r_oovf  <= n_oovf;
    end

    // term stores
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            quot_mem[q_waddr] <= q_wdata;
        end
        if (d_we) begin
            den_mem[idx[AW-1:0]] <= den_red;
        end
        if (issue) begin
            r_qrd <= quot_mem[r_j];
            r_drd <= den_mem[d_raddr];
        end
    end

    assign i_in.ready      = (r_state == psdmp_pkg::S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.quot_coef = r_oq;
    assign o_out.is_last   = r_olast;
    assign o_out.too_long  = r_oovf;

    `PSDMP_ASSERT_SAME(a_ovf_zero, r_ovalid && r_oovf, r_oq == '0, "too_long with nonzero term")
    `PSDMP_ASSERT_SAME(a_idle_empty, r_state == psdmp_pkg::S_IDLE, !mm_stat.busy && !r_rd_vld, "multiplier busy while idle")
    `PSDMP_ASSERT_SAME(a_issue_range, r_state == psdmp_pkg::S_ISSUE, r_j < r_i, "read index past current term")
    `PSDMP_ASSERT_SAME(a_term_bound, r_state == psdmp_pkg::S_IDLE, r_term <= TERM_LIMIT, "term index beyond limit")
    `PSDMP_ASSERT_NEXT(a_term_step, i_in.valid && i_in.ready && !i_in.start_series && !r_restart && r_term < TERM_LIMIT, r_term == $past(r_term) + TW'(1), "term index did not advance")

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = psdmp_pkg::COEF_W;
    localparam logic [CW-1:0] MOD = psdmp_pkg::MODULUS;
    localparam int DEPTH        = 1024;
    localparam int RANDOM_TERMS = 560;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam longint unsigned PRIME = 64'(psdmp_pkg::MODULUS);

    typedef struct packed {
        logic [CW-1:0] coef;
        logic          is_last;
        logic          too_long;
    } t_quot_term;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    psdmp_in_if  in_if ();
    psdmp_out_if out_if ();

    power_series_division_mod_prime #(
        .MAX_TERMS(DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state
    logic [CW-1:0] den_terms  [DEPTH];
    logic [CW-1:0] quot_terms [DEPTH];
    int unsigned   next_term       = 0;
    bit            restart_pending = 1'b0;

    t_quot_term quot_expected [$];

    int  items_sent    = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  cycles        = 0;
    bit  gaps_on       = 1'b1;

    function automatic t_quot_term divide_step(bit start, bit last,
                                               logic [CW-1:0] num,
                                               logic [CW-1:0] den);
        t_quot_term      r;
        longint unsigned acc;
        longint unsigned n;
        longint unsigned d;
        int unsigned     i;
        n   = 64'(num) % PRIME;
        d   = 64'(den) % PRIME;
        acc = 0;
        if (start || restart_pending) begin
            next_term = 0;
        end
        restart_pending = last;
        r.coef     = '0;
        r.is_last  = last;
        r.too_long = 1'b0;
        if (next_term >= DEPTH) begin
            r.too_long = 1'b1;
        end else begin
            i = next_term;
            den_terms[i] = d[CW-1:0];
            for (int j = 0; j < i; j++) begin
                acc = (acc + (64'(quot_terms[j]) * 64'(den_terms[i-j])) % PRIME) % PRIME;
            end
            r.coef        = CW'((n + PRIME - acc) % PRIME);
            quot_terms[i] = r.coef;
            next_term     = i + 1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CW-1:0] pick_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return CW'($urandom_range(0, MOD - 1));
        end
        if (r < 80) begin
            return CW'($urandom_range(0, 3));
        end
        if (r < 88) begin
            return CW'(MOD - $urandom_range(1, 3));
        end
        if (r < 94) begin
            return CW'(MOD + $urandom_range(0, 3));
        end
        return CW'($urandom());
    endfunction

    task automatic report(string msg);
        mismatches++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic send_term(bit start, bit last, logic [CW-1:0] num,
                             logic [CW-1:0] den);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.start_series <= start;
        in_if.last_term    <= last;
        in_if.num_coef     <= num;
        in_if.den_coef     <= den;
        do @(posedge i_clk); while (!in_if.ready);
        quot_expected.push_back(divide_step(start, last, num, den));
        items_sent++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (quot_expected.size() != 0);
    endtask

    task automatic test_directed();
        // first term after reset without start
        send_term(1'b0, 1'b1, MOD - 1, 1);
        // 1/(1-x), new division follows a last term
        send_term(1'b0, 1'b0, 1, 1);
        send_term(1'b0, 1'b0, 0, MOD - 1);
        send_term(1'b0, 1'b0, 0, 0);
        send_term(1'b0, 1'b1, 0, 0);
        // unreduced coefficients, leading denominator not one
        send_term(1'b1, 1'b0, '1, 0);
        send_term(1'b0, 1'b0, MOD, '1);
        send_term(1'b0, 1'b0, MOD - 1, MOD);
        send_term(1'b0, 1'b0, '1, MOD - 1);
        // start in the middle of a division
        send_term(1'b1, 1'b0, 7, MOD - 1);
        send_term(1'b0, 1'b0, 3, 2);
        send_term(1'b0, 1'b0, MOD - 1, MOD - 1);
        send_term(1'b0, 1'b1, 0, 1);
        send_term(1'b1, 1'b1, 0, 5);
        send_term(1'b1, 1'b0, 0, 1);
        send_term(1'b0, 1'b0, 0, 0);
        send_term(1'b0, 1'b1, 0, 0);
        send_term(1'b1, 1'b0, 30'h2AAAAAAA, 1);
        send_term(1'b0, 1'b0, 30'h15555555, 30'h2AAAAAAA);
        send_term(1'b0, 1'b1, 30'h3FFFFFFF, 30'h15555555);
        drain_results();
    endtask

    task automatic test_random();
        int  base;
        int  r;
        int  len;
        bit  start_flag;
        logic [CW-1:0] lead_den;
        base = items_sent;
        while (items_sent - base < RANDOM_TERMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    len = $urandom_range(1, 12);
                end else if (r < 95) begin
                    len = $urandom_range(13, 64);
                end else begin
                    len = $urandom_range(65, 160);
                end
                start_flag = restart_pending ? 1'($urandom_range(0, 1)) : 1'b1;
                lead_den   = ($urandom_range(0, 9) != 0) ? CW'(1) : pick_coef();
                send_term(start_flag, len == 1, pick_coef(), lead_den);
                for (int k = 1; k < len; k++) begin
                    send_term(1'b0, k == len - 1, pick_coef(), pick_coef());
                end
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_term($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                              pick_coef(), pick_coef());
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                drain_results();
            end
        end
        gaps_on = 1'b1;
    endtask

    // result checker and output backpressure
    initial begin
        int         stall;
        t_quot_term want;
        stall = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (quot_expected.size() == 0) begin
                    report($sformatf("unexpected transaction quot_coef=%0d",
                                     out_if.quot_coef));
                end else begin
                    want = quot_expected.pop_front();
                    results_seen++;
                    if (out_if.quot_coef !== want.coef) begin
                        report($sformatf("result %0d quot_coef got %0d want %0d",
                                         results_seen, out_if.quot_coef, want.coef));
                    end
                    if (out_if.is_last !== want.is_last) begin
                        report($sformatf("result %0d is_last got %b want %b",
                                         results_seen, out_if.is_last, want.is_last));
                    end
                    if (out_if.too_long !== want.too_long) begin
                        report($sformatf("result %0d too_long got %b want %b",
                                         results_seen, out_if.too_long, want.too_long));
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, quot_expected.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.start_series <= 1'b0;
        in_if.last_term    <= 1'b0;
        in_if.num_coef     <= '0;
        in_if.den_coef     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random();

        drain_results();
        repeat (64) @(posedge i_clk);

        $display("Sent %0d terms: directed edge values and random divisions with noise,",
                 items_sent);
        $display("under random input gaps and output stalls; checked %0d results.",
                 results_seen);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
